// File: sv/cllr_pkg.sv
package cllr_pkg;

  // Operation codes carried in the input tuser
  typedef enum logic [1:0] {
    FN_TOTAL = 2'd0,
    FN_MATCH = 2'd1,
    FN_QUERY = 2'd2,
    FN_NONE  = 2'd3
  } func_e;

  // Controller states, one-hot
  typedef enum logic [9:0] {
    S_CLEAR = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_READ  = 10'b00_0000_0100,
    S_LOAD  = 10'b00_0000_1000,
    S_NORM  = 10'b00_0001_0000,
    S_SQR   = 10'b00_0010_0000,
    S_ACC   = 10'b00_0100_0000,
    S_MUL   = 10'b00_1000_0000,
    S_RND   = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } state_e;

  localparam int unsigned FRAC_BITS = 28;
  localparam int unsigned MANT_BITS = 32;
  localparam logic [27:0] LN2_Q28   = 28'd186065279;
  localparam int unsigned RATIO_BITS = 23;
  localparam int unsigned LABEL_BITS = 9;

endpackage

// File: sv/class_log_likelihood_ratio_top.sv
// Count beats (total or match bump) do a memory read, then a write back.
// A query runs four operands of W bits (47 at defaults) through one shared log2
// unit, which normalizes one binary shift step per cycle and then runs 28 squaring
// iterations through one 32x32 multiplier.
// One item is in flight at a time. After reset a clearing pass
// zeroes both counter memories before the first beat is accepted.
module class_log_likelihood_ratio_top #(
  parameter int unsigned NUM_CLASSES = 256,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] class_id
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [22:0] log_ratio, [31:23] label_count
  output logic        m_axis_tuser    // [0] minus_infinity
);

  localparam int unsigned AW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int unsigned SUMW  = COUNT_BITS + AW;
  localparam int unsigned OPW   = SUMW + 7;
  localparam int unsigned NW    = (OPW > 32) ? OPW : 32;
  localparam int unsigned PW    = $clog2(NW);
  localparam int unsigned NSTEP = $clog2(NW);
  localparam int unsigned SEENW = $clog2(NUM_CLASSES + 1);
  localparam int unsigned LW    = (PW + 31 > 37) ? PW + 31 : 37;
  localparam logic [AW-1:0] CLR_LAST = AW'(NUM_CLASSES - 1);
  localparam logic signed [LW-1:0] LCLAMP = LW'(64'd100 << cllr_pkg::FRAC_BITS);

  // Counter memories
  logic [COUNT_BITS-1:0] tot_mem [NUM_CLASSES];
  logic [COUNT_BITS-1:0] mat_mem [NUM_CLASSES];

  cllr_pkg::state_e state_q, state_d;
  cllr_pkg::func_e  op_q, op_d;
  logic [AW-1:0]    addr_q, addr_d, clr_q, clr_d, waddr, raddr;
  logic             id_ok_q, id_ok_d;
  logic [COUNT_BITS-1:0] tot_rd_q, mat_rd_q, tot_wd, mat_wd, tc, mc;
  logic             tot_we, mat_we, in_acc;
  logic [SUMW-1:0]  tsum_q, tsum_d, msum_q, msum_d, to_q, to_d, tc_q, tc_d;
  logic [OPW-1:0]   mcs_q, mcs_d, mos_q, mos_d;
  logic [SUMW-1:0]  mo_v;
  logic [SEENW-1:0] seen_q, seen_d;
  logic [1:0]       k_q, k_d;
  logic [NW-1:0]    x_q, x_d, topmask;
  logic [PW-1:0]    p_q, p_d, step_q, step_d, sh;
  logic [31:0]      y_q, y_d;
  logic [63:0]      sq;
  logic [32:0]      sq_sh;
  logic [4:0]       it_q, it_d;
  logic [cllr_pkg::FRAC_BITS-1:0] frac_q, frac_d;
  logic signed [LW-1:0] acc_q, acc_d, cl, lg;
  logic [LW-2:0]    mag;
  logic             neg_q, neg_d;
  logic [63:0]      prod_q, prod_d, rsum;
  logic [23:0]      qv;
  logic [cllr_pkg::RATIO_BITS-1:0] ratio_q, ratio_d;
  logic             inf_q, inf_d;
  logic [cllr_pkg::LABEL_BITS-1:0] label_q, label_d;

  assign s_axis_tready = (state_q == cllr_pkg::S_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign raddr         = AW'(s_axis_tdata);
  assign m_axis_tvalid = (state_q == cllr_pkg::S_OUT);
  assign m_axis_tdata  = {label_q, ratio_q};
  assign m_axis_tuser  = inf_q;

  // Sequence counting, query operand setup and the shared log2 unit
  always_comb begin
    state_d = state_q; op_d = op_q; addr_d = addr_q; id_ok_d = id_ok_q; clr_d = clr_q;
    tsum_d = tsum_q; msum_d = msum_q; seen_d = seen_q;
    to_d = to_q; tc_d = tc_q; mcs_d = mcs_q; mos_d = mos_q;
    k_d = k_q; x_d = x_q; p_d = p_q; step_d = step_q; y_d = y_q; it_d = it_q;
    frac_d = frac_q; acc_d = acc_q; neg_d = neg_q; prod_d = prod_q;
    ratio_d = ratio_q; inf_d = inf_q; label_d = label_q;
    tot_we = 1'b0; mat_we = 1'b0; waddr = addr_q;
    tot_wd = tot_rd_q + COUNT_BITS'(1); mat_wd = mat_rd_q + COUNT_BITS'(1);
    tc = id_ok_q ? tot_rd_q : '0;
    mc = id_ok_q ? mat_rd_q : '0;
    mo_v = msum_q - SUMW'(mc);
    sh = PW'(1) << step_q;
    topmask = ~({NW{1'b1}} >> sh);
    sq = 64'(y_q) * 64'(y_q);
    sq_sh = sq[63:31];
    lg = LW'({p_q, frac_q});
    cl = (acc_q > LCLAMP) ? LCLAMP : ((acc_q < -LCLAMP) ? -LCLAMP : acc_q);
    mag = cl[LW-1] ? (LW-1)'(-cl) : cl[LW-2:0];
    rsum = prod_q + (64'd1 << 39);
    qv = rsum[63:40];
    unique case (state_q)
      cllr_pkg::S_CLEAR: begin
        tot_we = 1'b1; mat_we = 1'b1; waddr = clr_q; tot_wd = '0; mat_wd = '0;
        if (clr_q == CLR_LAST) state_d = cllr_pkg::S_IDLE;
        else clr_d = clr_q + AW'(1);
      end
      cllr_pkg::S_IDLE: begin
        if (in_acc) begin
          op_d    = cllr_pkg::func_e'(s_axis_tuser);
          addr_d  = raddr;
          id_ok_d = (32'(s_axis_tdata) < NUM_CLASSES);
          if (cllr_pkg::func_e'(s_axis_tuser) != cllr_pkg::FN_NONE)
            state_d = cllr_pkg::S_READ;
        end
      end
      cllr_pkg::S_READ: begin
        state_d = cllr_pkg::S_IDLE;
        unique case (op_q)
          cllr_pkg::FN_TOTAL: begin
            if (id_ok_q && !(&tot_rd_q)) begin
              tot_we = 1'b1;
              tsum_d = tsum_q + SUMW'(1);
              if (tot_rd_q == '0) seen_d = seen_q + SEENW'(1);
            end
          end
          cllr_pkg::FN_MATCH: begin
            if (id_ok_q && !(&mat_rd_q)) begin
              mat_we = 1'b1;
              msum_d = msum_q + SUMW'(1);
            end
          end
          cllr_pkg::FN_QUERY: begin
            tc_d  = SUMW'(tc);
            to_d  = tsum_q - SUMW'(tc);
            mcs_d = (OPW'(mc) << 6) + (OPW'(mc) << 5) + (OPW'(mc) << 2) + OPW'(1);
            mos_d = (OPW'(mo_v) << 6) + (OPW'(mo_v) << 5) + (OPW'(mo_v) << 2) + OPW'(1);
            label_d = (32'(seen_q) > 32'd511) ? 9'd511 : 9'(seen_q);
            k_d = 2'd0;
            acc_d = '0;
            if (tc == '0 || to_d == '0) begin
              inf_d = 1'b1;
              ratio_d = 23'h400000;
              state_d = cllr_pkg::S_OUT;
            end else begin
              inf_d = 1'b0;
              state_d = cllr_pkg::S_LOAD;
            end
          end
          default: ;
        endcase
      end
      cllr_pkg::S_LOAD: begin
        unique case (k_q)
          2'd0:    x_d = NW'(to_q);
          2'd1:    x_d = NW'(tc_q);
          2'd2:    x_d = NW'(mcs_q);
          default: x_d = NW'(mos_q);
        endcase
        p_d = PW'(NW - 1);
        step_d = PW'(NSTEP - 1);
        state_d = cllr_pkg::S_NORM;
      end
      cllr_pkg::S_NORM: begin
        // one binary normalizing step per cycle, widest first
        if ((x_q & topmask) == '0) begin
          x_d = x_q << sh;
          p_d = p_q - sh;
        end
        step_d = step_q - PW'(1);
        if (step_q == '0) begin
          y_d = x_d[NW-1 -: 32];
          it_d = '0;
          frac_d = '0;
          state_d = cllr_pkg::S_SQR;
        end
      end
      cllr_pkg::S_SQR: begin
        // square and renormalize, one fraction bit per cycle
        frac_d = {frac_q[cllr_pkg::FRAC_BITS-2:0], sq_sh[32]};
        y_d = sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
        if (it_q == 5'(cllr_pkg::FRAC_BITS - 1)) state_d = cllr_pkg::S_ACC;
        else it_d = it_q + 5'd1;
      end
      cllr_pkg::S_ACC: begin
        acc_d = k_q[0] ? acc_q - lg : acc_q + lg;
        if (k_q == 2'd3) state_d = cllr_pkg::S_MUL;
        else begin
          k_d = k_q + 2'd1;
          state_d = cllr_pkg::S_LOAD;
        end
      end
      cllr_pkg::S_MUL: begin
        neg_d = cl[LW-1];
        prod_d = 64'(mag) * 64'(cllr_pkg::LN2_Q28);
        state_d = cllr_pkg::S_RND;
      end
      cllr_pkg::S_RND: begin
        // round half away from zero, restore sign, saturate
        if (!neg_q) ratio_d = (qv > 24'd4194303) ? 23'h3FFFFF : qv[22:0];
        else ratio_d = (qv > 24'd4194304) ? 23'h400000 : 23'(24'd0 - qv);
        state_d = cllr_pkg::S_OUT;
      end
      cllr_pkg::S_OUT: begin
        if (m_axis_tready) state_d = cllr_pkg::S_IDLE;
      end
      default: state_d = cllr_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cllr_pkg::S_CLEAR;
      clr_q   <= '0;
      tsum_q  <= '0;
      msum_q  <= '0;
      seen_q  <= '0;
      k_q     <= '0;
      step_q  <= '0;
      it_q    <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      tsum_q  <= tsum_d;
      msum_q  <= msum_d;
      seen_q  <= seen_d;
      k_q     <= k_d;
      step_q  <= step_d;
      it_q    <= it_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q <= op_d; addr_q <= addr_d; id_ok_q <= id_ok_d;
    to_q <= to_d; tc_q <= tc_d; mcs_q <= mcs_d; mos_q <= mos_d;
    x_q <= x_d; p_q <= p_d; y_q <= y_d; frac_q <= frac_d;
    acc_q <= acc_d; neg_q <= neg_d; prod_q <= prod_d;
    ratio_q <= ratio_d; inf_q <= inf_d; label_q <= label_d;
  end

  // Memories: read at accept, write back in the cycle after
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tot_rd_q <= tot_mem[raddr];
      mat_rd_q <= mat_mem[raddr];
    end
    if (tot_we) tot_mem[waddr] <= tot_wd;
    if (mat_we) mat_mem[waddr] <= mat_wd;
  end

endmodule
